### design/adp4_pkg.sv
// Shared types, constants and coefficient tables of the 4-bit ADPCM decoder.
package adp4_pkg;

	localparam int POS_W    = 6;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 14;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int ACC_W    = 32;
	localparam int FRAC     = 11;
	localparam int ROUND    = 1024;
	localparam int SAT_MAX  = 32767;
	localparam int SAT_MIN  = -32768;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam coef_t C1_TAB [16] = '{
		14'sd0, 14'sd0, 14'sd1024, 14'sd4096,
		14'sd3584, 14'sd3072, 14'sd4608, 14'sd4200,
		14'sd4800, 14'sd5120, 14'sd2048, 14'sd1024,
		-14'sd1024, -14'sd1024, -14'sd2048, 14'sd0
	};

	localparam coef_t C2_TAB [16] = '{
		14'sd2048, 14'sd2048, 14'sd1024, -14'sd2048,
		-14'sd1536, -14'sd1024, -14'sd2560, -14'sd2248,
		-14'sd2300, -14'sd3072, -14'sd2048, -14'sd1024,
		14'sd1024, 14'sd0, 14'sd0, 14'sd0
	};

	typedef struct packed {
		logic        clear;
		logic        has_data;
		logic [3:0]  nib_hi;
		logic [3:0]  nib_lo;
		logic [3:0]  shift;
		coef_t       c1;
		coef_t       c2;
		logic        hi_last;
		logic        lo_last;
	} cmd_t;

endpackage

### design/adp4_front.sv
// Front end: takes block bytes, tracks header state and block position, emits commands.
module adp4_front #(
	parameter int BLOCK_SAMPLES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          is_header,
	input  logic [7:0]    data_byte,
	input  logic          clear_history,
	output logic          q_wr,
	output adp4_pkg::cmd_t q_cmd,
	input  logic          q_full
);

	localparam logic [adp4_pkg::POS_W:0] LAST_IDX = (adp4_pkg::POS_W+1)'(BLOCK_SAMPLES - 1);

	logic [3:0]               pred_q;
	logic [3:0]               shift_q;
	logic [adp4_pkg::POS_W-1:0] pos_q;
	logic                     accept;
	logic [adp4_pkg::POS_W:0] sidx_hi;
	logic [adp4_pkg::POS_W:0] sidx_lo;
	logic                     hi_last;
	logic                     lo_last;

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign q_wr    = accept && (!is_header || clear_history);
	assign sidx_hi = {pos_q, 1'b0};
	assign sidx_lo = {pos_q, 1'b1};
	assign hi_last = (sidx_hi >= LAST_IDX);
	assign lo_last = (sidx_lo >= LAST_IDX);

	always_comb begin
		q_cmd.clear    = clear_history;
		q_cmd.has_data = !is_header;
		q_cmd.nib_hi   = data_byte[7:4];
		q_cmd.nib_lo   = data_byte[3:0];
		q_cmd.shift    = shift_q;
		q_cmd.c1       = adp4_pkg::C1_TAB[pred_q];
		q_cmd.c2       = adp4_pkg::C2_TAB[pred_q];
		q_cmd.hi_last  = hi_last;
		q_cmd.lo_last  = lo_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q  <= '0;
			shift_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (is_header) begin
				pred_q  <= data_byte[7:4];
				shift_q <= data_byte[3:0];
				pos_q   <= '0;
			end else if (hi_last || lo_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(sidx_hi <= LAST_IDX))
		else $error("block position ran past the last sample");
`endif

endmodule

### design/adp4_cmdq.sv
// Two-entry command queue between front and back end.
module adp4_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  adp4_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd,
	output adp4_pkg::cmd_t rd_data,
	output logic           empty
);

	adp4_pkg::cmd_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= 2'd2) && ((cnt_q == 2'd1) == (wp_q != rp_q)))
		else $error("command queue count and pointers disagree");
`endif

endmodule

### design/adp4_back.sv
// Back end: predicts and clamps samples from queued commands, keeps history, holds result beat.
module adp4_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  adp4_pkg::cmd_t q_cmd,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output logic signed [15:0] sample,
	output logic           last_of_pair,
	output logic           last_of_block
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	logic [1:0]                            state_q;
	adp4_pkg::cmd_t                        cmd_q;
	logic                                  lo_q;
	adp4_pkg::sample_t                     h1_q;
	adp4_pkg::sample_t                     h2_q;
	logic signed [adp4_pkg::PROD_W-1:0]    p1_q;
	logic signed [adp4_pkg::PROD_W-1:0]    p2_q;
	logic signed [adp4_pkg::ACC_W-1:0]     base_q;
	logic                                  ov_q;
	adp4_pkg::sample_t                     sample_q;
	logic                                  lop_q;
	logic                                  lob_q;

	logic [3:0]                            nib;
	logic signed [adp4_pkg::ACC_W-1:0]     nib_ext;
	logic signed [adp4_pkg::ACC_W-1:0]     base_c;
	logic signed [adp4_pkg::PROD_W-1:0]    p1_c;
	logic signed [adp4_pkg::PROD_W-1:0]    p2_c;
	logic signed [adp4_pkg::ACC_W-1:0]     sum_c;
	logic signed [adp4_pkg::ACC_W-1:0]     shr_c;
	adp4_pkg::sample_t                     sat_c;
	logic                                  cur_last;
	logic                                  do_out;
	logic                                  clr_en;

	assign q_rd     = (state_q == ST_IDLE) && !q_empty;
	assign clr_en   = q_rd && q_cmd.clear;
	assign do_out   = (state_q == ST_ADD) && (!ov_q || pop);
	assign nib      = lo_q ? cmd_q.nib_lo : cmd_q.nib_hi;
	assign cur_last = lo_q ? cmd_q.lo_last : cmd_q.hi_last;
	assign nib_ext  = {{(adp4_pkg::ACC_W-4){nib[3]}}, nib};
	assign base_c   = (nib_ext << cmd_q.shift) << adp4_pkg::FRAC;
	assign p1_c     = adp4_pkg::PROD_W'(cmd_q.c1) * adp4_pkg::PROD_W'(h1_q);
	assign p2_c     = adp4_pkg::PROD_W'(cmd_q.c2) * adp4_pkg::PROD_W'(h2_q);
	assign sum_c    = base_q + adp4_pkg::ACC_W'(p1_q) + adp4_pkg::ACC_W'(p2_q)
			+ adp4_pkg::ACC_W'(adp4_pkg::ROUND);
	assign shr_c    = sum_c >>> adp4_pkg::FRAC;

	always_comb begin
		priority if (shr_c > adp4_pkg::ACC_W'(adp4_pkg::SAT_MAX)) begin
			sat_c = adp4_pkg::SAMPLE_W'(adp4_pkg::SAT_MAX);
		end else if (shr_c < adp4_pkg::ACC_W'(adp4_pkg::SAT_MIN)) begin
			sat_c = adp4_pkg::SAMPLE_W'(adp4_pkg::SAT_MIN);
		end else begin
			sat_c = shr_c[adp4_pkg::SAMPLE_W-1:0];
		end
	end

	assign empty         = !ov_q;
	assign sample        = sample_q;
	assign last_of_pair  = lop_q;
	assign last_of_block = lob_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_MUL) begin
			p1_q   <= p1_c;
			p2_q   <= p2_c;
			base_q <= base_c;
		end
		if (do_out) begin
			sample_q <= sat_c;
			lop_q    <= lo_q;
			lob_q    <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q    <= 1'b0;
			h1_q    <= '0;
			h2_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (do_out) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd) begin
						lo_q <= 1'b0;
						if (q_cmd.clear) begin
							h1_q <= '0;
							h2_q <= '0;
						end
						state_q <= q_cmd.has_data ? ST_MUL : ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (do_out) begin
						h1_q <= sat_c;
						h2_q <= h1_q;
						if (!lo_q && !cmd_q.hi_last) begin
							lo_q    <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_wait_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && ov_q && !pop) |=> (state_q == ST_ADD))
		else $error("sample dropped while result register was held");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !pop) |=> ($stable(sample_q) && $stable(lob_q) && ov_q))
		else $error("held result beat changed");
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!do_out && !clr_en) |=> ($stable(h1_q) && $stable(h2_q)))
		else $error("history changed without a sample or clear");
`endif

endmodule

### design/dsp_adpcm4_decoder.sv
// Top level of the 4-bit ADPCM block decoder: front end, command queue, back end.
//
//  channel   direction  handshake        beat
//  input     in         push / full      is_header, data_byte, clear_history
//  result    out        pop / empty      sample, last_of_pair, last_of_block
//
// A header byte is taken and yields no result; with clear_history it
// also queues a clear. A data byte queues one command; the back end fetches it,
// then runs each sample through a product stage and a sum and clamp stage; a
// byte yields two samples, or one where its high nibble ends the block.
// The two-entry queue lets the front accept bytes while the back works.
// A result beat waits in the output register while pop is low; the back end
// stalls in its sum stage until that register frees. Reset clears control state and history.
module dsp_adpcm4_decoder #(
	parameter int BLOCK_SAMPLES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               is_header,
	input  logic [7:0]         data_byte,
	input  logic               clear_history,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	output logic               last_of_pair,
	output logic               last_of_block
);

	logic           q_wr;
	logic           q_full;
	logic           q_rd;
	logic           q_empty;
	adp4_pkg::cmd_t q_wr_cmd;
	adp4_pkg::cmd_t q_rd_cmd;

	adp4_front #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.is_header    (is_header),
		.data_byte    (data_byte),
		.clear_history(clear_history),
		.q_wr         (q_wr),
		.q_cmd        (q_wr_cmd),
		.q_full       (q_full)
	);

	adp4_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(q_wr_cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rd_data(q_rd_cmd),
		.empty  (q_empty)
	);

	adp4_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_rd_cmd),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.sample       (sample),
		.last_of_pair (last_of_pair),
		.last_of_block(last_of_block)
	);

endmodule
